/* design/dfc_pkg.sv */
// dfc_pkg: shared types and constants for the distinct flow counter
// no dependencies; used by dfc_hash and distinct_flow_counter
`default_nettype none

package dfc_pkg;

    // defaults for the top-level parameters
    localparam int TABLE_SIZE_DEF = 4096;
    localparam int MAX_PROBES_DEF = 16;

    // header codes
    localparam logic [15:0] IPV4_TYPE = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // hash: seed, and multiply by 31 as (h << 5) - h
    localparam int          HASH_W     = 64;
    localparam logic [63:0] HASH_SEED  = 64'd17;
    localparam int          HASH_SHIFT = 5;

    // flow key and count
    localparam int          KEY_W     = 96;
    localparam int          COUNT_W   = 13;
    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    // one packet's parsed header fields
    typedef struct packed {
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } pkt_t;

    // one lookup result
    typedef struct packed {
        logic [12:0] distinct_count;
        logic        counted_packet;
        logic        new_flow;
        logic        table_overflow;
    } res_t;

    // status from the hash unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } hash_stat_t;

endpackage

`default_nettype wire

/* design/dfc_chan_if.sv */
// dfc_chan_if: valid/ready channel carrying one payload per transaction
// no dependencies; payload type set per instance
`default_nettype none

interface dfc_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/dfc_ram.sv */
// dfc_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`default_nettype none

module dfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/dfc_hash.sv */
// dfc_hash: iterative flow hash on one shared adder, bytewise start-slot reduction
// depends on dfc_pkg
`default_nettype none

module dfc_hash #(
    parameter int TABLE_SIZE = dfc_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [31:0]                   src_addr,
    input  wire logic [31:0]                   dst_addr,
    input  wire logic [15:0]                   sport,
    input  wire logic [15:0]                   dport,
    output      dfc_pkg::hash_stat_t           stat,
    output      logic [$clog2(TABLE_SIZE)-1:0] index
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam bit IS_POW2 = ((1 << IDX_W) == TABLE_SIZE);
    localparam logic [IDX_W:0] TSIZE = (IDX_W+1)'(TABLE_SIZE);
    // remainder step works on the running remainder with one hash byte below it
    localparam int X_W = IDX_W + 8;
    localparam logic [X_W-1:0] TSIZE_X = X_W'(TABLE_SIZE);
    localparam logic [8:0]     RECIP   = 9'((longint'(1) << X_W) / longint'(TABLE_SIZE));

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_RQUO,
        S_RSUB,
        S_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [dfc_pkg::HASH_W-1:0] acc_reg, acc_next;
    logic [1:0]                 step_reg, step_next;
    logic [2:0]                 byte_reg, byte_next;
    logic [IDX_W-1:0]           rem_reg, rem_next;
    logic [7:0]                 quo_reg, quo_next;

    logic [dfc_pkg::HASH_W-1:0] mix_in;
    logic [dfc_pkg::HASH_W-1:0] mix_sum;
    logic [X_W-1:0]             red_x;
    logic [X_W+7:0]             recip_prod;
    logic [X_W-1:0]             quo_mul;
    logic [X_W-1:0]             red_diff;
    logic [X_W-1:0]             red_sub;

    // operand for the current mixing step
    always_comb
    begin
        case (step_reg)
            2'd0:    mix_in = {32'd0, src_addr};
            2'd1:    mix_in = {32'd0, dst_addr};
            2'd2:    mix_in = {48'd0, sport};
            default: mix_in = {48'd0, dport};
        endcase
    end

    // shared unit: h*31 + x, modulo 2^64
    assign mix_sum = (acc_reg << dfc_pkg::HASH_SHIFT) - acc_reg + mix_in;

    // remainder step: estimate the quotient by reciprocal, then one correction
    assign red_x      = {rem_reg, acc_reg[dfc_pkg::HASH_W-1 -: 8]};
    assign recip_prod = (X_W+8)'(red_x) * (X_W+8)'(RECIP);
    assign quo_mul    = X_W'(quo_reg) * TSIZE_X;
    assign red_diff   = red_x - quo_mul;
    assign red_sub    = red_diff - TSIZE_X;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        step_next  = step_reg;
        byte_next  = byte_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    acc_next   = dfc_pkg::HASH_SEED;
                    step_next  = '0;
                    state_next = S_MIX;
                end
            end
            S_MIX:
            begin
                acc_next  = mix_sum;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    byte_next = '0;
                    rem_next  = '0;
                    if (IS_POW2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RQUO;
                    end
                end
            end
            S_RQUO:
            begin
                quo_next   = 8'(recip_prod >> X_W);
                state_next = S_RSUB;
            end
            S_RSUB:
            begin
                acc_next  = acc_reg << 8;
                byte_next = byte_reg + 3'd1;
                if (red_diff >= TSIZE_X)
                begin
                    rem_next = red_sub[IDX_W-1:0];
                end
                else
                begin
                    rem_next = red_diff[IDX_W-1:0];
                end
                if (byte_reg == 3'd7)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RQUO;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            acc_reg   <= '0;
            step_reg  <= '0;
            byte_reg  <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            step_reg  <= step_next;
            byte_reg  <= byte_next;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    // status and start slot
    assign stat.busy = (state_reg != S_IDLE);
    assign stat.done = (state_reg == S_DONE);
    assign index     = IS_POW2 ? acc_reg[IDX_W-1:0] : rem_reg;

    // a start is only issued while the unit is idle
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("hash start while busy");

    // done lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.done)
        else $error("hash done held");

    // reduction always leaves a slot inside the table
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> ({1'b0, index} < TSIZE))
        else $error("hash index out of range");

endmodule

`default_nettype wire

/* design/distinct_flow_counter.sv */
// distinct_flow_counter: top level, probe sequencer, key store and result register
// depends on dfc_pkg, dfc_chan_if, dfc_hash, dfc_ram
//
// usage
//   pkt carries one packet's parsed header fields per transaction; res returns
//   exactly one result per packet: running distinct count and lookup marks.
//   packets that are not IPv4 TCP/UDP are answered with the current count.
//   after reset the key store is swept clear, every slot, with pkt.ready
//   low; then the block takes one packet at a time.
//   an ignored packet goes straight to its result; a counted packet is hashed
//   in the four hash mixing steps, then probed slot by slot with a
//   read-then-compare per probe, plus a bytewise reduction of the hash
//   for table sizes that are not a power of two.
//   pkt.ready returns as the result is loaded into the output register, so
//   the block takes no new packet until the last one's result is loaded.
//   results sit in an output register: while res stalls the block still takes
//   and works the next packet, and holds before delivering its result until
//   the register is free.
//   the count saturates at 8191; a key neither found nor given a free slot
//   within MAX_PROBES slots (TABLE_SIZE if smaller) is reported as table_overflow and not stored.
`default_nettype none

module distinct_flow_counter #(
    parameter int TABLE_SIZE = dfc_pkg::TABLE_SIZE_DEF,
    parameter int MAX_PROBES = dfc_pkg::MAX_PROBES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    dfc_chan_if.sink    pkt,
    dfc_chan_if.source  res
);

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int LIMIT   = (MAX_PROBES < TABLE_SIZE) ? MAX_PROBES : TABLE_SIZE;
    localparam int PROBE_W = $clog2(LIMIT + 1);
    localparam int ENTRY_W = dfc_pkg::KEY_W + 1;
    localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(TABLE_SIZE - 1);
    localparam logic [PROBE_W-1:0] PROBE_LIM = PROBE_W'(LIMIT);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HSTART,
        S_HWAIT,
        S_READ,
        S_CMP,
        S_RESP
    } state_t;

    state_t                      state_reg, state_next;
    logic [dfc_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [IDX_W-1:0]            slot_reg, slot_next;
    logic [IDX_W-1:0]            clr_reg, clr_next;
    logic [PROBE_W-1:0]          probe_reg, probe_next;
    logic [dfc_pkg::COUNT_W-1:0] total_reg, total_next;
    logic                        counted_reg, counted_next;
    logic                        fresh_reg, fresh_next;
    logic                        over_reg, over_next;
    logic                        res_valid_reg, res_valid_next;
    dfc_pkg::res_t               res_data_reg, res_data_next;

    dfc_pkg::hash_stat_t         hstat;
    logic [IDX_W-1:0]            hindex;
    logic                        hstart;

    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic [ENTRY_W-1:0]          ram_wdata;
    logic                        ram_re;
    logic [ENTRY_W-1:0]          ram_rdata;

    logic                        pkt_take;
    logic                        pkt_flow;
    logic                        rd_valid;
    logic                        rd_match;
    logic [PROBE_W-1:0]          probe_inc;
    logic [IDX_W-1:0]            slot_inc;

    // shared hash unit
    dfc_hash #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_hash (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (hstart),
        .src_addr (key_reg[95:64]),
        .dst_addr (key_reg[63:32]),
        .sport    (key_reg[31:16]),
        .dport    (key_reg[15:0]),
        .stat     (hstat),
        .index    (hindex)
    );

    // key store, one entry per slot: valid bit over the key
    dfc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // handshakes and packet classification
    assign pkt.ready = (state_reg == S_IDLE);
    assign pkt_take  = pkt.valid && pkt.ready;
    assign pkt_flow  = (pkt.data.ether_type == dfc_pkg::IPV4_TYPE) &&
                       ((pkt.data.ip_protocol == dfc_pkg::PROTO_TCP) ||
                        (pkt.data.ip_protocol == dfc_pkg::PROTO_UDP));
    assign res.valid = res_valid_reg;
    assign res.data  = res_data_reg;

    // probe compare and slot stepping
    assign rd_valid  = ram_rdata[dfc_pkg::KEY_W];
    assign rd_match  = (ram_rdata[dfc_pkg::KEY_W-1:0] == key_reg);
    assign probe_inc = probe_reg + 1'b1;
    assign slot_inc  = (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;

    // memory port control
    assign hstart    = (state_reg == S_HSTART);
    assign ram_re    = (state_reg == S_READ);
    assign ram_we    = (state_reg == S_CLEAR) || ((state_reg == S_CMP) && !rd_valid);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_reg : slot_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, key_reg};

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        slot_next      = slot_reg;
        clr_next       = clr_reg;
        probe_next     = probe_reg;
        total_next     = total_reg;
        counted_next   = counted_reg;
        fresh_next     = fresh_reg;
        over_next      = over_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_data_next  = res_data_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pkt_take)
                begin
                    key_next     = {pkt.data.src_addr, pkt.data.dst_addr,
                                    pkt.data.sport, pkt.data.dport};
                    counted_next = pkt_flow;
                    fresh_next   = 1'b0;
                    over_next    = 1'b0;
                    state_next   = pkt_flow ? S_HSTART : S_RESP;
                end
            end
            S_HSTART:
            begin
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                if (hstat.done)
                begin
                    slot_next  = hindex;
                    probe_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (!rd_valid)
                begin
                    // free slot: key is written this cycle
                    fresh_next = 1'b1;
                    if (total_reg != dfc_pkg::COUNT_MAX)
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    state_next = S_RESP;
                end
                else if (rd_match)
                begin
                    state_next = S_RESP;
                end
                else if (probe_inc == PROBE_LIM)
                begin
                    over_next  = 1'b1;
                    state_next = S_RESP;
                end
                else
                begin
                    probe_next = probe_inc;
                    slot_next  = slot_inc;
                    state_next = S_READ;
                end
            end
            S_RESP:
            begin
                // load the output register once it is free
                if (!res_valid_reg || res.ready)
                begin
                    res_valid_next               = 1'b1;
                    res_data_next.distinct_count = total_reg;
                    res_data_next.counted_packet = counted_reg;
                    res_data_next.new_flow       = fresh_reg;
                    res_data_next.table_overflow = over_reg;
                    state_next                   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            key_reg       <= '0;
            slot_reg      <= '0;
            clr_reg       <= '0;
            probe_reg     <= '0;
            total_reg     <= '0;
            counted_reg   <= 1'b0;
            fresh_reg     <= 1'b0;
            over_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            slot_reg      <= slot_next;
            clr_reg       <= clr_next;
            probe_reg     <= probe_next;
            total_reg     <= total_next;
            counted_reg   <= counted_next;
            fresh_reg     <= fresh_next;
            over_reg      <= over_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    // a result never marks both a new flow and an overflow
    a_marks_excl: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_data_reg.new_flow && res_data_reg.table_overflow))
        else $error("new flow and overflow both set");

    // lookup marks only on counted packets
    a_marks_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_data_reg.new_flow || res_data_reg.table_overflow))
        |-> res_data_reg.counted_packet)
        else $error("lookup mark on ignored packet");

    // the distinct count never goes down
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("flow total decreased");

    // the probe count stays inside the limit
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (probe_reg < PROBE_LIM))
        else $error("probe past limit");

    // the hash unit is working while the sequencer waits on it
    a_hash_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HWAIT) |-> hstat.busy)
        else $error("waiting on an idle hash unit");

endmodule

`default_nettype wire
